[src/cddl_pkg.sv]
// Shared types, constants and character functions for the decimal display line block.
// No dependencies; every other module of the block except cddl_checker imports this package.
`timescale 1ns / 1ps

package cddl_pkg;

    // What the back end has to do with one queued item
    typedef enum logic [1:0] {
        KIND_OVF   = 2'd0,
        KIND_NOSIG = 2'd1,
        KIND_NUM   = 2'd2
    } kind_t;

    localparam int COUNT_W    = 32;
    localparam int GATE_W     = 2;
    localparam int COL_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int LOW_W      = 16;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    // Item queue between front and back end
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Double dabble: two bits shifted in per cycle
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W / 2 - 1);

    localparam logic [GATE_W-1:0] GATE_MODE_RESET = 2'd2;
    localparam logic [GATE_W-1:0] GATE_TEN_SEC    = 2'd3;

    localparam logic [COL_W-1:0] MSG_LAST_COL  = 4'd9;
    localparam logic [COL_W-1:0] LINE_LAST_COL = 4'd15;
    localparam logic [COL_W-1:0] COL_DOT       = 4'd3;
    localparam logic [COL_W-1:0] COL_SEP       = 4'd7;
    localparam logic [COL_W-1:0] COL_COMMA     = 4'd11;
    localparam logic [COL_W-1:0] COL_RIGHT_10S = 4'd12;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'h2C;

    // Text tables, 16 characters each, leftmost character in the top byte
    localparam logic [127:0] LINE_TEXT  = "   .   ,     MHz";
    localparam logic [127:0] OVF_TEXT   = "Over flow!      ";
    localparam logic [127:0] NOSIG_TEXT = "No Signal!      ";

    typedef struct packed {
        kind_t               kind;
        logic [COUNT_W-1:0]  count;
        logic [GATE_W-1:0]   gate_mode;
    } item_t;

    typedef struct packed {
        kind_t               kind;
        logic [GATE_W-1:0]   gate_mode;
        logic [BCD_W-1:0]    bcd;
    } line_t;

    // Pick one character of a 16-character text
    function automatic logic [CHAR_W-1:0] text_char(input logic [127:0] text,
                                                    input logic [COL_W-1:0] col);
        logic [COL_W-1:0] rev;
        rev = LINE_LAST_COL - col;
        return text[{rev, 3'b000} +: CHAR_W];
    endfunction

    // Character at one column before leading-zero blanking
    function automatic logic [CHAR_W-1:0] char_at(input line_t ln,
                                                  input logic [COL_W-1:0] col);
        logic [COL_W-1:0] start;
        logic [4:0]       idx;
        logic [3:0]       dig;
        logic [CHAR_W-1:0] ch;
        start = (ln.gate_mode == GATE_TEN_SEC) ? COL_RIGHT_10S
                                               : 4'd8 + {2'b00, ln.gate_mode};
        idx = 5'd8 + {3'b000, ln.gate_mode} - {1'b0, col}
            - {4'b0000, (col < COL_SEP)} - {4'b0000, (col < COL_DOT)};
        if (col == COL_RIGHT_10S) begin
            idx = 5'd0;
        end
        dig = ln.bcd[{idx[3:0], 2'b00} +: 4];
        case (ln.kind)
            KIND_OVF:   ch = text_char(OVF_TEXT, col);
            KIND_NOSIG: ch = text_char(NOSIG_TEXT, col);
            default: begin
                if (col == COL_COMMA && ln.gate_mode == GATE_TEN_SEC) begin
                    ch = CHAR_COMMA;
                end else if (col > start || col == COL_DOT || col == COL_SEP) begin
                    ch = text_char(LINE_TEXT, col);
                end else begin
                    ch = CHAR_ZERO + {3'b000, dig};
                end
            end
        endcase
        return ch;
    endfunction

endpackage

[src/cddl_front.sv]
// Front end: gate mode register, item classification and redraw/skip state.
// Depends on cddl_pkg.
`timescale 1ns / 1ps

module cddl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cddl_pkg::GATE_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cddl_pkg::COUNT_W-1:0]  s_count,
    input  logic                          s_overflow,
    input  logic                          s_signal_present,
    input  logic                          s_redraw_request,
    output logic                          push_valid,
    input  logic                          push_ready,
    output cddl_pkg::item_t               push_item
);
    import cddl_pkg::*;

    logic [GATE_W-1:0] gate_mode_reg;
    logic [LOW_W-1:0]  shown_low_reg, shown_low_next;
    logic              redraw_pending_reg, redraw_pending_next;
    logic              pending;
    logic              skip;
    logic              accept;
    kind_t             kind;

    // Classify the offered item
    always_comb begin
        pending             = redraw_pending_reg | s_redraw_request;
        skip                = 1'b0;
        shown_low_next      = shown_low_reg;
        redraw_pending_next = pending;
        kind                = KIND_NUM;
        if (s_overflow) begin
            kind                = KIND_OVF;
            redraw_pending_next = 1'b1;
        end else if (!s_signal_present || s_count == '0) begin
            kind                = KIND_NOSIG;
            redraw_pending_next = 1'b1;
        end else if (!pending && s_count[LOW_W-1:0] == shown_low_reg) begin
            skip = 1'b1;
        end else begin
            redraw_pending_next = 1'b0;
            shown_low_next      = s_count[LOW_W-1:0];
        end
    end

    assign s_ready    = push_ready;
    assign accept     = s_valid & s_ready;
    assign push_valid = s_valid & ~skip;
    assign push_item  = '{kind: kind, count: s_count, gate_mode: gate_mode_reg};

    // Hold configuration and display state; update on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_mode_reg      <= GATE_MODE_RESET;
            shown_low_reg      <= '0;
            redraw_pending_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                gate_mode_reg <= cfg_wr_data;
            end
            if (accept) begin
                shown_low_reg      <= shown_low_next;
                redraw_pending_reg <= redraw_pending_next;
            end
        end
    end

endmodule

[src/cddl_queue.sv]
// Two-entry item queue between the front end and the converter.
// Depends on cddl_pkg.
`timescale 1ns / 1ps

module cddl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cddl_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output cddl_pkg::item_t  out_item
);
    import cddl_pkg::*;

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // Store incoming items
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/cddl_conv.sv]
// Binary to BCD converter: double dabble, two bits per cycle, 16 steps after the load.
// Depends on cddl_pkg. A message item is offered on the output in the cycle after it is loaded.
`timescale 1ns / 1ps

module cddl_conv (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cddl_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output cddl_pkg::line_t  out_line
);
    import cddl_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COUNT_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    kind_t              kind_reg;
    logic [GATE_W-1:0]  gate_reg;
    logic [BCD_W+COUNT_W-1:0] shift_next;

    // One double dabble step: correct each digit, then shift in one bit
    function automatic logic [BCD_W+COUNT_W-1:0] dd_step(
        input logic [BCD_W+COUNT_W-1:0] w);
        logic [BCD_W+COUNT_W-1:0] v;
        v = w;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (v[COUNT_W + 4*i +: 4] >= 4'd5) begin
                v[COUNT_W + 4*i +: 4] = v[COUNT_W + 4*i +: 4] + 4'd3;
            end
        end
        return {v[BCD_W+COUNT_W-2:0], 1'b0};
    endfunction

    assign shift_next = dd_step(dd_step({bcd_reg, bin_reg}));
    assign in_ready   = ~busy_reg & (~done_reg | out_ready);
    assign out_valid  = done_reg;
    assign out_line   = '{kind: kind_reg, gate_mode: gate_reg, bcd: bcd_reg};

    // Load, iterate, and hold the finished line until the emitter takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                kind_reg <= in_item.kind;
                gate_reg <= in_item.gate_mode;
                bin_reg  <= in_item.count;
                bcd_reg  <= '0;
                step_reg <= '0;
                busy_reg <= (in_item.kind == KIND_NUM);
                done_reg <= (in_item.kind != KIND_NUM);
            end else if (busy_reg) begin
                bcd_reg  <= shift_next[BCD_W+COUNT_W-1:COUNT_W];
                bin_reg  <= shift_next[COUNT_W-1:0];
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (done_reg && out_ready) begin
                done_reg <= 1'b0;
            end
        end
    end

endmodule

[src/cddl_emit.sv]
// Line emitter: walks the columns of one line and drives the registered result channel.
// Depends on cddl_pkg.
`timescale 1ns / 1ps

module cddl_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cddl_pkg::line_t               in_line,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cddl_pkg::COL_W-1:0]    m_column,
    output logic [cddl_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last
);
    import cddl_pkg::*;

    line_t              line_reg;
    logic               active_reg;
    logic [COL_W-1:0]   col_reg;
    logic               m_valid_reg;
    logic [COL_W-1:0]   m_column_reg;
    logic [CHAR_W-1:0]  m_char_reg;
    logic               m_last_reg;
    logic [CHAR_W-1:0]  raw_char;
    logic [CHAR_W-1:0]  char_next;
    logic               zero0;
    logic               zero1;
    logic               advance;
    logic               is_last;

    assign raw_char = char_at(line_reg, col_reg);
    assign zero0    = (char_at(line_reg, 4'd0) == CHAR_ZERO);
    assign zero1    = (char_at(line_reg, 4'd1) == CHAR_ZERO);

    // Blank leading zeros in the two leftmost columns
    always_comb begin
        char_next = raw_char;
        if (line_reg.kind == KIND_NUM) begin
            if (col_reg == 4'd0 && zero0) begin
                char_next = CHAR_SPACE;
            end else if (col_reg == 4'd1 && zero0 && zero1) begin
                char_next = CHAR_SPACE;
            end
        end
    end

    assign is_last  = (col_reg == ((line_reg.kind == KIND_NUM) ? LINE_LAST_COL
                                                               : MSG_LAST_COL));
    assign advance  = active_reg & (~m_valid_reg | m_ready);
    assign in_ready = ~active_reg | (advance & is_last);

    // Advance one column per free output slot; take the next line at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg  <= 1'b1;
                m_column_reg <= col_reg;
                m_char_reg   <= char_next;
                m_last_reg   <= is_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (in_valid && in_ready) begin
                line_reg   <= in_line;
                col_reg    <= '0;
                active_reg <= 1'b1;
            end else if (advance) begin
                col_reg <= col_reg + 1'b1;
                if (is_last) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_column    = m_column_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

endmodule

[src/count_to_decimal_display_line_top.sv]
// Decimal display line builder for a frequency counter display.
// Input channel (s_*): one measurement per transfer (32-bit count, overflow,
// signal-present and redraw-request flags). Result channel (m_*): one
// character per transfer (column, 7-bit ASCII code, last on the final one).
// An overflow gives "Over flow!", a missing signal or zero count gives
// "No Signal!" on columns 0..9; a count gives the full 16-column line with
// the digits placed by gate_mode (written through cfg_wr_en / cfg_wr_data).
// A count whose low 16 bits match the last shown one, with no redraw
// pending, gives no output.
// Each item is registered in the queue, in the converter (a count only after
// its double dabble steps) and in the emitter's line and output registers.
// The converter can work on the next count while the emitter sends out the
// characters of the previous line.
// A two-entry queue lets the input side keep accepting while the output
// stalls; when the receiver holds m_ready low, the output holds and the
// queue fills, then s_ready drops. Synchronous reset: gate_mode = 2 (1 s),
// redraw pending, output empty.
// Depends on cddl_pkg, cddl_front, cddl_queue, cddl_conv, cddl_emit.
`timescale 1ns / 1ps

module count_to_decimal_display_line_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cddl_pkg::GATE_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cddl_pkg::COUNT_W-1:0]  s_count,
    input  logic                          s_overflow,
    input  logic                          s_signal_present,
    input  logic                          s_redraw_request,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cddl_pkg::COL_W-1:0]    m_column,
    output logic [cddl_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last
);
    import cddl_pkg::*;

    logic  push_valid, push_ready;
    item_t push_item;
    logic  q_valid, q_ready;
    item_t q_item;
    logic  line_valid, line_ready;
    line_t line;

    // Classify and filter measurements
    cddl_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_count          (s_count),
        .s_overflow       (s_overflow),
        .s_signal_present (s_signal_present),
        .s_redraw_request (s_redraw_request),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    // Decouple front and back end
    cddl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Convert counts to BCD
    cddl_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (line_valid),
        .out_ready (line_ready),
        .out_line  (line)
    );

    // Emit the characters of each line
    cddl_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (line_valid),
        .in_ready    (line_ready),
        .in_line     (line),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_column    (m_column),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

endmodule

[src/cddl_checker.sv]
// Port-level checker for the decimal display line block, bound to the top level.
// Depends on the top level's clock, reset and result channel ports only.
`timescale 1ns / 1ps

module cddl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_column,
    input logic [6:0] m_char_code,
    input logic       m_last
);

    // Output channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column) && $stable(m_char_code)
                                && $stable(m_last))
        else $error("stalled result changed");

    // Characters of a line come in ascending column order
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            !m_valid || m_column == 4'($past(m_column) + 4'd1))
        else $error("column sequence broken");

    // A line ends on column 9 with '!' or on column 15 with 'z'
    a_last_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |->
            (m_column == 4'd9 && m_char_code == 7'h21) ||
            (m_column == 4'd15 && m_char_code == 7'h7A))
        else $error("bad last character");

endmodule

bind count_to_decimal_display_line_top cddl_checker u_cddl_checker (.*);

[tb/tb_count_to_decimal_display_line_top.sv]
// Self-checking testbench for count_to_decimal_display_line_top: drives measurements,
// predicts every display character and checks each output transfer in order.
// Depends on cddl_pkg and the block's top module.
`timescale 1ns / 1ps

module tb_count_to_decimal_display_line_top;

    localparam int COUNT_W        = cddl_pkg::COUNT_W;
    localparam int GATE_W         = cddl_pkg::GATE_W;
    localparam int COL_W          = cddl_pkg::COL_W;
    localparam int CHAR_W         = cddl_pkg::CHAR_W;
    localparam int LINE_CHARS     = 16;
    localparam int MSG_CHARS      = 10;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_MAX     = 10;

    localparam logic [GATE_W-1:0] GATE_10MS = 2'd0;
    localparam logic [GATE_W-1:0] GATE_100MS = 2'd1;
    localparam logic [GATE_W-1:0] GATE_1S = 2'd2;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;

    // Text patterns, leftmost character in the top byte
    localparam logic [127:0] FREQ_PATTERN  = "   .   ,     MHz";
    localparam logic [127:0] OVF_PATTERN   = "Over flow!      ";
    localparam logic [127:0] NOSIG_PATTERN = "No Signal!      ";

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } rx_style_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } disp_char_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [GATE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [COUNT_W-1:0]  s_count = '0;
    logic                s_overflow = 1'b0;
    logic                s_signal_present = 1'b0;
    logic                s_redraw_request = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [COL_W-1:0]    m_column;
    logic [CHAR_W-1:0]   m_char_code;
    logic                m_last;

    // Predictor state
    logic [GATE_W-1:0]   gate_now = cddl_pkg::GATE_MODE_RESET;
    logic [15:0]         shown_low = '0;
    logic                redraw_due = 1'b1;
    disp_char_t          disp_q[$];

    int        error_cnt = 0;
    int        burst_left = 0;
    int        tx_gap_max = 4;
    rx_style_t rx_style = RX_OPEN;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        rx_tick = 0;
    int        quiet_cycles = 0;
    logic [COUNT_W-1:0] last_count = '0;

    count_to_decimal_display_line_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_count          (s_count),
        .s_overflow       (s_overflow),
        .s_signal_present (s_signal_present),
        .s_redraw_request (s_redraw_request),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column         (m_column),
        .m_char_code      (m_char_code),
        .m_last           (m_last)
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] pattern_char(input logic [127:0] text, input int col);
        return text[(15 - col) * 8 +: 8];
    endfunction

    // Work out the characters one accepted measurement produces; return how many
    function automatic int predict_display_line(input logic [COUNT_W-1:0] cnt,
                                                input logic ovf, input logic sig,
                                                input logic rdr);
        logic [7:0]         line [LINE_CHARS];
        logic [127:0]       msg;
        logic [COUNT_W-1:0] rest;
        int                 pos;
        int                 len;
        if (rdr) begin
            redraw_due = 1'b1;
        end
        if (ovf || !sig || cnt == '0) begin
            redraw_due = 1'b1;
            msg = ovf ? OVF_PATTERN : NOSIG_PATTERN;
            for (int i = 0; i < LINE_CHARS; i++) begin
                line[i] = pattern_char(msg, i);
            end
            len = MSG_CHARS;
        end else begin
            // Skip an unchanged count unless a redraw is due
            if (redraw_due) begin
                redraw_due = 1'b0;
            end else if (cnt[15:0] == shown_low) begin
                return 0;
            end
            shown_low = cnt[15:0];
            for (int i = 0; i < LINE_CHARS; i++) begin
                line[i] = pattern_char(FREQ_PATTERN, i);
            end
            // Walk digits right to left, hopping over the separators
            rest = cnt;
            pos = 8 + int'(gate_now);
            if (gate_now == cddl_pkg::GATE_TEN_SEC) begin
                line[pos] = ASCII_COMMA;
                pos++;
            end
            while (pos >= 0) begin
                line[pos] = ASCII_ZERO + 8'(rest % 10);
                rest = rest / 10;
                pos--;
                if (pos == 3 || pos == 7 || pos == 11) begin
                    pos--;
                end
            end
            // Blank leading zeros in the two leftmost columns
            if (line[0] == ASCII_ZERO) begin
                line[0] = ASCII_SPACE;
                if (line[1] == ASCII_ZERO) begin
                    line[1] = ASCII_SPACE;
                end
            end
            len = LINE_CHARS;
        end
        for (int i = 0; i < len; i++) begin
            disp_q.push_back('{column: COL_W'(i), char_code: line[i][CHAR_W-1:0],
                               last: (i == len - 1)});
        end
        return len;
    endfunction

    // Offer one measurement in bursts with random gaps; predict on transfer
    task automatic send_measurement(input logic [COUNT_W-1:0] cnt, input logic ovf,
                                    input logic sig, input logic rdr, output int n_chars);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_count          <= cnt;
        s_overflow       <= ovf;
        s_signal_present <= sig;
        s_redraw_request <= rdr;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        n_chars = predict_display_line(cnt, ovf, sig, rdr);
        last_count = cnt;
        @(negedge aclk);
    endtask

    // Stop offering, wait for every expected character, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (disp_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_gate_mode(input logic [GATE_W-1:0] mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        gate_now = mode;
    endtask

    // Count with a spread of decimal lengths
    function automatic logic [COUNT_W-1:0] pick_count();
        logic [COUNT_W-1:0] limit;
        int                 sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return $urandom;
        end else if (sel < 6) begin
            limit = 10;
            repeat ($urandom_range(0, 8)) limit = limit * 10;
            return $urandom % limit;
        end else if (sel == 6) begin
            return $urandom_range(1, 20);
        end else if (sel == 7) begin
            return 32'hFFFF_FFFF - $urandom_range(0, 1000);
        end
        return $urandom_range(1, 99999);
    endfunction

    // Reset defaults, skip rules, messages, gate modes, digit drop and blanking
    task automatic test_directed_cases();
        int n;
        send_measurement(32'h0001_0000, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'h0002_0000, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd1, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd1, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'h0001_0001, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd1, 1'b0, 1'b1, 1'b1, n);
        send_measurement(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd123, 1'b1, 1'b1, 1'b0, n);
        send_measurement(32'd0, 1'b1, 1'b0, 1'b0, n);
        send_measurement(32'd5, 1'b0, 1'b0, 1'b0, n);
        send_measurement(32'd0, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd5, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd12345, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd10000000, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd100000000, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd999999999, 1'b0, 1'b1, 1'b0, n);
        write_gate_mode(GATE_10MS);
        send_measurement(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, n);
        send_measurement(32'd7, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd1000000, 1'b0, 1'b1, 1'b0, n);
        write_gate_mode(cddl_pkg::GATE_TEN_SEC);
        send_measurement(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, n);
        send_measurement(32'd7, 1'b0, 1'b1, 1'b0, n);
        send_measurement(32'd100000000, 1'b0, 1'b1, 1'b0, n);
    endtask

    // Mostly valid counts with repeats, plus message and redraw noise
    task automatic test_random_lines(input logic [GATE_W-1:0] mode, input int n_lines,
                                     input rx_style_t style, input int gap_max);
        logic [COUNT_W-1:0] cnt;
        logic               ovf;
        logic               sig;
        logic               rdr;
        int                 r;
        int                 n;
        int                 shown;
        write_gate_mode(mode);
        rx_style = style;
        tx_gap_max = gap_max;
        shown = 0;
        while (shown < n_lines) begin
            r   = $urandom_range(0, 99);
            cnt = pick_count();
            ovf = 1'b0;
            sig = 1'b1;
            rdr = ($urandom_range(0, 9) == 0);
            if (r < 7) begin
                ovf = 1'b1;
                sig = 1'($urandom_range(0, 1));
            end else if (r < 14) begin
                sig = 1'b0;
            end else if (r < 17) begin
                cnt = '0;
            end else if (r < 30) begin
                cnt = last_count;
            end else if (r < 37) begin
                cnt = {16'($urandom), last_count[15:0]};
            end
            send_measurement(cnt, ovf, sig, rdr, n);
            if (n > 0) begin
                shown++;
            end
        end
    endtask

    // Hold the output off while lines keep coming so the input stalls
    task automatic test_output_backpressure();
        int n;
        write_gate_mode(GATE_100MS);
        rx_style = RX_OPEN;
        tx_gap_max = 0;
        hold_req++;
        for (int i = 0; i < 10; i++) begin
            send_measurement(pick_count() | 32'd1, 1'b0, 1'b1, 1'b1, n);
        end
        wait_idle();
    endtask

    // Receiver: long hold-offs on request, otherwise the selected stall style
    always @(negedge aclk) begin
        logic ready_next;
        rx_tick = rx_tick + 1;
        if (hold_left == 0 && hold_seen != hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            ready_next = 1'b0;
        end else begin
            case (rx_style)
                RX_RANDOM:  ready_next = ($urandom_range(0, 2) != 0);
                RX_PATTERN: ready_next = ((rx_tick % 11) > 3);
                default:    ready_next = 1'b1;
            endcase
        end
        m_ready <= ready_next;
    end

    // Check each output transfer against the oldest expected character
    always @(posedge aclk) begin
        disp_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (disp_q.size() == 0) begin
                error_cnt++;
                if (error_cnt <= REPORT_MAX) begin
                    $display("unexpected char: column %0d code %h last %b",
                             m_column, m_char_code, m_last);
                end
            end else begin
                want = disp_q.pop_front();
                if (want.column !== m_column || want.char_code !== m_char_code
                        || want.last !== m_last) begin
                    error_cnt++;
                    if (error_cnt <= REPORT_MAX) begin
                        $display("char mismatch (exp/got): col %0d/%0d code %h/%h",
                                 want.column, m_column, want.char_code, m_char_code);
                        $display("    last %b/%b", want.last, m_last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_output_backpressure();
        test_random_lines(GATE_100MS, 37, RX_RANDOM, 4);
        test_random_lines(cddl_pkg::GATE_TEN_SEC, 37, RX_PATTERN, 6);
        test_random_lines(GATE_10MS, 37, RX_OPEN, 0);
        test_random_lines(GATE_1S, 37, RX_RANDOM, 3);

        wait_idle();
        if (disp_q.size() != 0) begin
            error_cnt += disp_q.size();
        end
        if (error_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
